### rtl/onl_pkg.sv
// ----------------------------------------------------------------------------
// onl_pkg: shared types and constants for the object notation lexer
// Token kinds, lexer modes, token and queue record types, character helpers.
// ----------------------------------------------------------------------------
package onl_pkg;

    localparam int POS_BITS   = 32;
    localparam int QUE_DEPTH  = 4;
    localparam int QUE_AW     = $clog2(QUE_DEPTH);

    localparam logic [4:0] K_SPACE   = 5'd0;
    localparam logic [4:0] K_COMMENT = 5'd1;
    localparam logic [4:0] K_NEWLINE = 5'd2;
    localparam logic [4:0] K_STRING  = 5'd3;
    localparam logic [4:0] K_INT     = 5'd4;
    localparam logic [4:0] K_FLOAT   = 5'd5;
    localparam logic [4:0] K_LBRACE  = 5'd6;
    localparam logic [4:0] K_RBRACE  = 5'd7;
    localparam logic [4:0] K_COLON   = 5'd8;
    localparam logic [4:0] K_LBRACK  = 5'd9;
    localparam logic [4:0] K_RBRACK  = 5'd10;
    localparam logic [4:0] K_COMMA   = 5'd11;
    localparam logic [4:0] K_STAR    = 5'd12;
    localparam logic [4:0] K_PLUS    = 5'd13;
    localparam logic [4:0] K_MINUS   = 5'd14;
    localparam logic [4:0] K_SLASH   = 5'd15;
    localparam logic [4:0] K_BOOL    = 5'd16;
    localparam logic [4:0] K_END     = 5'd17;
    localparam logic [4:0] K_ERROR   = 5'd18;

    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_END  = 1'b1;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [31:0] ROW_MAX   = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        M_DEFAULT = 3'd0,
        M_SPACE   = 3'd1,
        M_COMMENT = 3'd2,
        M_STRING  = 3'd3,
        M_NUMBER  = 3'd4,
        M_WORD    = 3'd5,
        M_ERROR   = 3'd6
    } t_mode;

    typedef struct packed {
        logic [4:0]  kind;
        logic [31:0] first;
        logic [31:0] final_pos;
        logic [31:0] row;
    } t_token;

    // one queue entry: the tokens one input item causes (one or two)
    typedef struct packed {
        logic   two;
        t_token tok0;
        t_token tok1;
    } t_rec;

    function automatic t_token mk_tok(input logic [4:0] kind,
                                      input logic [POS_BITS-1:0] first,
                                      input logic [POS_BITS-1:0] last,
                                      input logic [31:0] row);
        t_token t;
        t.kind      = kind;
        t.first     = 32'(first);
        t.final_pos = 32'(last);
        t.row       = row;
        return t;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    // single-character punctuation; returns {hit, kind}
    function automatic logic [5:0] single_kind(input logic [7:0] c);
        logic [5:0] r;
        case (c)
            8'h7B:   r = {1'b1, K_LBRACE};
            8'h7D:   r = {1'b1, K_RBRACE};
            8'h3A:   r = {1'b1, K_COLON};
            8'h5B:   r = {1'b1, K_LBRACK};
            8'h5D:   r = {1'b1, K_RBRACK};
            8'h2C:   r = {1'b1, K_COMMA};
            8'h2A:   r = {1'b1, K_STAR};
            8'h2B:   r = {1'b1, K_PLUS};
            8'h2D:   r = {1'b1, K_MINUS};
            8'h2F:   r = {1'b1, K_SLASH};
            default: r = {1'b0, K_SPACE};
        endcase
        return r;
    endfunction

    // expected lower-case letter at index k of "false" or "true"
    function automatic logic [7:0] word_char(input logic is_false, input logic [2:0] k);
        logic [7:0] r;
        r = 8'h00;
        if (is_false) begin
            case (k)
                3'd0:    r = 8'h66;
                3'd1:    r = 8'h61;
                3'd2:    r = 8'h6C;
                3'd3:    r = 8'h73;
                3'd4:    r = 8'h65;
                default: r = 8'h00;
            endcase
        end else begin
            case (k)
                3'd0:    r = 8'h74;
                3'd1:    r = 8'h72;
                3'd2:    r = 8'h75;
                3'd3:    r = 8'h65;
                default: r = 8'h00;
            endcase
        end
        return r;
    endfunction

endpackage

### rtl/onl_front.sv
// ----------------------------------------------------------------------------
// onl_front: lexer front end
// Accepts one item per cycle while the queue has room, updates the lexer state
// and builds a record of the tokens that the item completes.
// ----------------------------------------------------------------------------
module onl_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_op,
    input  logic [7:0]      i_char,
    input  logic            i_q_full,
    output logic            o_push,
    output onl_pkg::t_rec   o_rec
);

    onl_pkg::t_mode              r_mode, n_mode;
    logic [4:0]                  r_pkind, n_pkind;
    logic [onl_pkg::POS_BITS-1:0] r_pfirst, n_pfirst;
    logic [onl_pkg::POS_BITS-1:0] r_pos, n_pos;
    logic [31:0]                 r_row, n_row;
    logic [2:0]                  r_wcnt, n_wcnt;
    logic                        r_wfalse, n_wfalse;

    logic                        accept;
    logic                        a_v, b_v, again, match;
    onl_pkg::t_token             a_tok, b_tok;
    logic [onl_pkg::POS_BITS-1:0] prev_pos;
    logic [2:0]                  wlen;
    logic [7:0]                  lc;
    logic [5:0]                  sk;

    assign accept   = i_valid && !i_q_full;
    assign prev_pos = (r_pos == '0) ? '0 : r_pos - onl_pkg::POS_BITS'(1);
    assign wlen     = r_wfalse ? 3'd5 : 3'd4;
    assign lc       = ((i_char >= 8'h41) && (i_char <= 8'h5A)) ? i_char + 8'd32 : i_char;
    assign match    = (r_wcnt < wlen) && (lc == onl_pkg::word_char(r_wfalse, r_wcnt));
    assign sk       = onl_pkg::single_kind(i_char);

    always_comb begin
        n_mode   = r_mode;
        n_pkind  = r_pkind;
        n_pfirst = r_pfirst;
        n_pos    = r_pos;
        n_row    = r_row;
        n_wcnt   = r_wcnt;
        n_wfalse = r_wfalse;
        a_v      = 1'b0;
        b_v      = 1'b0;
        again    = 1'b0;
        a_tok    = onl_pkg::mk_tok(r_pkind, r_pfirst, prev_pos, r_row);
        b_tok    = onl_pkg::mk_tok(onl_pkg::K_END, r_pos, r_pos, r_row);

        if (i_op == onl_pkg::OP_END) begin
            if (r_mode == onl_pkg::M_WORD) begin
                a_v   = 1'b1;
                a_tok = onl_pkg::mk_tok(onl_pkg::K_ERROR, r_pfirst, prev_pos, r_row);
            end else if (r_mode != onl_pkg::M_DEFAULT && r_mode != onl_pkg::M_ERROR) begin
                a_v = 1'b1;
            end
            b_v      = 1'b1;
            n_mode   = onl_pkg::M_DEFAULT;
            n_pkind  = onl_pkg::K_SPACE;
            n_pfirst = '0;
            n_pos    = '0;
            n_row    = 32'd1;
            n_wcnt   = 3'd0;
            n_wfalse = 1'b0;
        end else begin
            unique case (r_mode)
                onl_pkg::M_DEFAULT: again = 1'b1;
                onl_pkg::M_SPACE:   again = (i_char != onl_pkg::CH_SPACE);
                onl_pkg::M_COMMENT: again = (i_char == onl_pkg::CH_NL);
                onl_pkg::M_NUMBER: begin
                    if (i_char == onl_pkg::CH_DOT) n_pkind = onl_pkg::K_FLOAT;
                    else if (!onl_pkg::is_digit(i_char)) again = 1'b1;
                end
                onl_pkg::M_STRING: begin
                    if (i_char == onl_pkg::CH_QUOTE) begin
                        a_v    = 1'b1;
                        a_tok  = onl_pkg::mk_tok(onl_pkg::K_STRING, r_pfirst, r_pos, r_row);
                        n_mode = onl_pkg::M_DEFAULT;
                    end
                end
                onl_pkg::M_WORD: begin
                    a_v = 1'b0;
                    if (match) begin
                        n_wcnt = r_wcnt + 3'd1;
                        if (r_wcnt + 3'd1 == wlen) begin
                            a_v    = 1'b1;
                            a_tok  = onl_pkg::mk_tok(onl_pkg::K_BOOL, r_pfirst, r_pos, r_row);
                            n_mode = onl_pkg::M_DEFAULT;
                            n_wcnt = 3'd0;
                        end
                    end else begin
                        a_v    = 1'b1;
                        a_tok  = onl_pkg::mk_tok(onl_pkg::K_ERROR, r_pfirst, r_pos, r_row);
                        n_mode = onl_pkg::M_ERROR;
                        n_wcnt = 3'd0;
                    end
                end
                default: n_mode = onl_pkg::M_ERROR;
            endcase

            if (again) begin
                // close whatever run was open, then treat the char from scratch
                if (r_mode != onl_pkg::M_DEFAULT) a_v = 1'b1;
                n_mode = onl_pkg::M_DEFAULT;
                if (onl_pkg::is_digit(i_char)) begin
                    n_mode   = onl_pkg::M_NUMBER;
                    n_pkind  = onl_pkg::K_INT;
                    n_pfirst = r_pos;
                end else if (i_char == onl_pkg::CH_SPACE) begin
                    n_mode   = onl_pkg::M_SPACE;
                    n_pkind  = onl_pkg::K_SPACE;
                    n_pfirst = r_pos;
                end else if (i_char == onl_pkg::CH_HASH) begin
                    n_mode   = onl_pkg::M_COMMENT;
                    n_pkind  = onl_pkg::K_COMMENT;
                    n_pfirst = r_pos;
                end else if (i_char == onl_pkg::CH_QUOTE) begin
                    n_mode   = onl_pkg::M_STRING;
                    n_pkind  = onl_pkg::K_STRING;
                    n_pfirst = r_pos;
                end else if (i_char == onl_pkg::CH_NL) begin
                    if (r_row != onl_pkg::ROW_MAX) n_row = r_row + 32'd1;
                    b_v   = 1'b1;
                    b_tok = onl_pkg::mk_tok(onl_pkg::K_NEWLINE, r_pos, r_pos, n_row);
                end else if (sk[5]) begin
                    b_v   = 1'b1;
                    b_tok = onl_pkg::mk_tok(sk[4:0], r_pos, r_pos, r_row);
                end else if (lc == 8'h66 || lc == 8'h74) begin
                    n_mode   = onl_pkg::M_WORD;
                    n_pkind  = onl_pkg::K_BOOL;
                    n_pfirst = r_pos;
                    n_wfalse = (lc == 8'h66);
                    n_wcnt   = 3'd1;
                end else begin
                    b_v    = 1'b1;
                    b_tok  = onl_pkg::mk_tok(onl_pkg::K_ERROR, r_pos, r_pos, r_row);
                    n_mode = onl_pkg::M_ERROR;
                end
            end

            if (r_pos != '1) n_pos = r_pos + onl_pkg::POS_BITS'(1);
        end
    end

    assign o_push    = accept && (a_v || b_v);
    assign o_rec.two  = a_v && b_v;
    assign o_rec.tok0 = a_v ? a_tok : b_tok;
    assign o_rec.tok1 = b_tok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= onl_pkg::M_DEFAULT;
            r_pkind  <= onl_pkg::K_SPACE;
            r_pfirst <= '0;
            r_pos    <= '0;
            r_row    <= 32'd1;
            r_wcnt   <= 3'd0;
            r_wfalse <= 1'b0;
        end else if (accept) begin
            r_mode   <= n_mode;
            r_pkind  <= n_pkind;
            r_pfirst <= n_pfirst;
            r_pos    <= n_pos;
            r_row    <= n_row;
            r_wcnt   <= n_wcnt;
            r_wfalse <= n_wfalse;
        end
    end

    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == onl_pkg::M_ERROR && accept && i_op == onl_pkg::OP_CHAR)
        |=> (r_mode == onl_pkg::M_ERROR))
        else $error("error mode left before end of input");

    a_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_op == onl_pkg::OP_END)
        |=> (r_mode == onl_pkg::M_DEFAULT && r_pos == '0 && r_row == 32'd1))
        else $error("state not cleared after end of input");

endmodule

### rtl/onl_queue.sv
// ----------------------------------------------------------------------------
// onl_queue: token record queue
// Small register FIFO between the lexer front end and the output back end.
// ----------------------------------------------------------------------------
module onl_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  onl_pkg::t_rec   i_rec,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output onl_pkg::t_rec   o_rec
);

    onl_pkg::t_rec                r_mem [onl_pkg::QUE_DEPTH];
    logic [onl_pkg::QUE_AW-1:0]   r_wr, r_rd;
    logic [onl_pkg::QUE_AW:0]     r_cnt, n_cnt;
    logic                         do_pop;

    assign o_full  = (r_cnt == (onl_pkg::QUE_AW + 1)'(onl_pkg::QUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_rec   = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !do_pop) n_cnt = r_cnt + (onl_pkg::QUE_AW + 1)'(1);
        else if (!i_push && do_pop) n_cnt = r_cnt - (onl_pkg::QUE_AW + 1)'(1);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_rec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + onl_pkg::QUE_AW'(1);
            if (do_pop) r_rd <= r_rd + onl_pkg::QUE_AW'(1);
            r_cnt <= n_cnt;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (onl_pkg::QUE_AW + 1)'(onl_pkg::QUE_DEPTH))
        else $error("queue count out of range");

endmodule

### rtl/onl_back.sv
// ----------------------------------------------------------------------------
// onl_back: token output back end
// Pops queue records and delivers their one or two tokens through an output
// register, flagging the last token of each record.
// ----------------------------------------------------------------------------
module onl_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  onl_pkg::t_rec   i_q_rec,
    output logic            o_q_pop,
    input  logic            i_stall,
    output logic            o_valid,
    output onl_pkg::t_token o_tok,
    output logic            o_last
);

    logic            r_valid;
    onl_pkg::t_token r_tok;
    logic            r_last;
    logic            r_has2;
    onl_pkg::t_token r_tok2;
    logic            load;

    assign load    = !r_valid || !i_stall;
    assign o_q_pop = load && !r_has2 && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_has2  <= 1'b0;
        end else if (load) begin
            if (r_has2) begin
                r_valid <= 1'b1;
                r_has2  <= 1'b0;
            end else if (i_q_valid) begin
                r_valid <= 1'b1;
                r_has2  <= i_q_rec.two;
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_has2) begin
                r_tok  <= r_tok2;
                r_last <= 1'b1;
            end else if (i_q_valid) begin
                r_tok  <= i_q_rec.tok0;
                r_last <= !i_q_rec.two;
                r_tok2 <= i_q_rec.tok1;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_tok   = r_tok;
    assign o_last  = r_last;

    a_second_behind_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_has2 |-> (r_valid && !r_last))
        else $error("second token held without a first one on the output");

endmodule

### rtl/object_notation_lexer_top.sv
// ----------------------------------------------------------------------------
// object_notation_lexer_top: streaming lexer for a JSON-like notation
// Front end lexes one character per cycle, while the queue has room, into a
// record queue; back end delivers the completed tokens with position and line.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------
//  input   | in        | i_valid / o_stall  | i_op, i_in_char
//  tokens  | out       | o_valid / i_stall  | o_token_kind/first/final/row,
//          |           |                    | o_last_of_run
//
//  One item is accepted per cycle while the four-entry record queue has room.
//  Each token takes its own slot on the output port: an item closing a run and
//  starting a single-character token yields two, so the output port sets the
//  rate for such items. Tokens pass through the queue entry and then the back
//  end output register. Synchronous active-low reset clears the lexer state
//  and queue. Output stall backs up through the queue to o_stall.
// ----------------------------------------------------------------------------
module object_notation_lexer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_op,
    input  logic [7:0]  i_in_char,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [4:0]  o_token_kind,
    output logic [31:0] o_token_first,
    output logic [31:0] o_token_final,
    output logic [31:0] o_token_row,
    output logic        o_last_of_run
);

    logic            q_full, q_push, q_valid, q_pop;
    onl_pkg::t_rec   f_rec, q_rec;
    onl_pkg::t_token tok;

    onl_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_op     (i_op),
        .i_char   (i_in_char),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_rec    (f_rec)
    );

    onl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_rec   (f_rec),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_rec   (q_rec)
    );

    onl_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_rec   (q_rec),
        .o_q_pop   (q_pop),
        .i_stall   (i_stall),
        .o_valid   (o_valid),
        .o_tok     (tok),
        .o_last    (o_last_of_run)
    );

    assign o_stall       = q_full;
    assign o_token_kind  = tok.kind;
    assign o_token_first = tok.first;
    assign o_token_final = tok.final_pos;
    assign o_token_row   = tok.row;

endmodule
